[rtl/rgbcf_pkg.sv]
// Package for the RGB565 cross-fade and dim compositor.
// Holds the transaction structs, register codes, constants and arithmetic helpers.
// Depends on nothing.
package rgbcf_pkg;

  typedef struct packed {
    logic [5:0]  column;
    logic [5:0]  row;
    logic [15:0] front_pixel;
    logic [15:0] target_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [5:0] out_column;
    logic [5:0] out_row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned NUM_STAGES = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSSFADE_AMOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL        = 2'd2;

  localparam logic [7:0]  DIM_RESET      = 8'd255;
  localparam logic [7:0]  FULL_SCALE     = 8'd255;
  localparam logic [5:0]  GRAD_START_ROW = 6'd39;
  localparam logic [7:0]  GRAD_TOP       = 8'd238;
  localparam logic [7:0]  GRAD_FLOOR     = 8'd35;
  localparam logic [15:0] ROUND_HALF     = 16'd127;
  localparam logic [15:0] RECIP_255      = 16'h8081;
  localparam logic [13:0] RECIP_31       = 14'd8457;
  localparam logic [14:0] RECIP_63       = 15'd16645;

  // Widens a 5-bit channel to floor(c * 255 / 31) by reciprocal multiplication.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [12:0] x;
    logic [26:0] p;
    x = 13'(c) * 13'(FULL_SCALE);
    p = 27'(x) * 27'(RECIP_31);
    return p[25:18];
  endfunction

  // Widens a 6-bit channel to floor(c * 255 / 63) by reciprocal multiplication.
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [13:0] x;
    logic [28:0] p;
    x = 14'(c) * 14'(FULL_SCALE);
    p = 29'(x) * 29'(RECIP_63);
    return p[27:20];
  endfunction

  // Exact floor(t / 255) for 16-bit t up to 65279, where the quotient fits 8 bits.
  function automatic logic [7:0] div255(input logic [15:0] t);
    logic [31:0] p;
    p = 32'(t) * 32'(RECIP_255);
    return p[30:23];
  endfunction

  // Lower-third brightness gradient.
  function automatic logic [7:0] gradient(input logic [5:0] row);
    logic [5:0] d;
    logic [7:0] drop;
    logic [7:0] g;
    d    = row - GRAD_START_ROW;
    drop = {d[4:0], 3'b000};
    if (row < GRAD_START_ROW) begin
      g = FULL_SCALE;
    end else if (drop >= (GRAD_TOP - GRAD_FLOOR)) begin
      g = GRAD_FLOOR;
    end else begin
      g = GRAD_TOP - drop;
    end
    return g;
  endfunction

endpackage

[rtl/rgb565_crossfade_dim_compositor_core.sv]
// Top level of the RGB565 cross-fade and dim compositor.
// A five-stage pipeline; uses rgbcf_pkg for types, constants and arithmetic helpers.
//
// Usage:
// Pixels enter on in_data_i with in_valid_i; a transaction completes on a rising
// edge with in_valid_i high and in_stall_o low. Composited pixels leave on
// out_data_o with out_valid_o and complete when out_stall_i is low.
// One transaction per cycle goes in and one comes out while out_stall_i is low.
// A transaction passes five register stages: channel widening, cross-fade
// products, divide by 255, level scaling, and the final divide by 255 into the
// output register. out_valid_o rises once the transaction reaches the output
// register, and the result leaves at the first later edge with out_stall_i low.
// When the receiver stalls, the output register holds its transaction and the
// stages behind it keep filling empty slots, so in_stall_o rises only once the
// whole pipeline is full.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; an index beyond
// the list is ignored. Write only while the pipeline is empty; this is not enforced.
// Reset empties the pipeline and restores blend off, amount 0 and dim 255.
module rgb565_crossfade_dim_compositor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rgbcf_pkg::pix_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rgbcf_pkg::pix_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rgbcf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbcf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic       blend_en_q;
  logic [7:0] xfade_q;
  logic [7:0] dim_q;

  logic [rgbcf_pkg::NUM_STAGES-1:0] valid_q;
  logic [rgbcf_pkg::NUM_STAGES-1:0] valid_d;
  logic [rgbcf_pkg::NUM_STAGES-1:0] en;

  logic [5:0]  s1_col_q, s1_row_q;
  logic [7:0]  s1_fr_q, s1_fg_q, s1_fb_q, s1_tr_q, s1_tg_q, s1_tb_q;
  logic [7:0]  s1_amt_q, s1_grad_q, s1_dim_q;

  logic [5:0]  s2_col_q, s2_row_q;
  logic [15:0] s2_r_q, s2_g_q, s2_b_q, s2_lvl_q;

  logic [5:0]  s3_col_q, s3_row_q;
  logic [7:0]  s3_r_q, s3_g_q, s3_b_q, s3_lvl_q;

  logic [5:0]  s4_col_q, s4_row_q;
  logic [15:0] s4_r_q, s4_g_q, s4_b_q;

  rgbcf_pkg::pix_out_t out_q;
  logic [7:0]          s2_inv_amt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_en_q <= 1'b0;
      xfade_q    <= '0;
      dim_q      <= rgbcf_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgbcf_pkg::REG_BLEND_ENABLE:     blend_en_q <= cfg_wdata_i[0];
        rgbcf_pkg::REG_CROSSFADE_AMOUNT: xfade_q    <= cfg_wdata_i;
        rgbcf_pkg::REG_DIM_LEVEL:        dim_q      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[rgbcf_pkg::NUM_STAGES-1] = !valid_q[rgbcf_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = rgbcf_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < rgbcf_pkg::NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s2_inv_amt = rgbcf_pkg::FULL_SCALE - s1_amt_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_col_q  <= in_data_i.column;
      s1_row_q  <= in_data_i.row;
      s1_fr_q   <= rgbcf_pkg::widen5(in_data_i.front_pixel[15:11]);
      s1_fg_q   <= rgbcf_pkg::widen6(in_data_i.front_pixel[10:5]);
      s1_fb_q   <= rgbcf_pkg::widen5(in_data_i.front_pixel[4:0]);
      s1_tr_q   <= rgbcf_pkg::widen5(in_data_i.target_pixel[15:11]);
      s1_tg_q   <= rgbcf_pkg::widen6(in_data_i.target_pixel[10:5]);
      s1_tb_q   <= rgbcf_pkg::widen5(in_data_i.target_pixel[4:0]);
      s1_amt_q  <= blend_en_q ? xfade_q : 8'd0;
      s1_grad_q <= rgbcf_pkg::gradient(in_data_i.row);
      s1_dim_q  <= dim_q;
    end
    if (en[1]) begin
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
      s2_r_q   <= 16'(s1_fr_q) * 16'(s2_inv_amt) + 16'(s1_tr_q) * 16'(s1_amt_q)
                  + rgbcf_pkg::ROUND_HALF;
      s2_g_q   <= 16'(s1_fg_q) * 16'(s2_inv_amt) + 16'(s1_tg_q) * 16'(s1_amt_q)
                  + rgbcf_pkg::ROUND_HALF;
      s2_b_q   <= 16'(s1_fb_q) * 16'(s2_inv_amt) + 16'(s1_tb_q) * 16'(s1_amt_q)
                  + rgbcf_pkg::ROUND_HALF;
      s2_lvl_q <= 16'(s1_dim_q) * 16'(s1_grad_q) + rgbcf_pkg::ROUND_HALF;
    end
    if (en[2]) begin
      s3_col_q <= s2_col_q;
      s3_row_q <= s2_row_q;
      s3_r_q   <= rgbcf_pkg::div255(s2_r_q);
      s3_g_q   <= rgbcf_pkg::div255(s2_g_q);
      s3_b_q   <= rgbcf_pkg::div255(s2_b_q);
      s3_lvl_q <= rgbcf_pkg::div255(s2_lvl_q);
    end
    if (en[3]) begin
      s4_col_q <= s3_col_q;
      s4_row_q <= s3_row_q;
      s4_r_q   <= 16'(s3_r_q) * 16'(s3_lvl_q) + rgbcf_pkg::ROUND_HALF;
      s4_g_q   <= 16'(s3_g_q) * 16'(s3_lvl_q) + rgbcf_pkg::ROUND_HALF;
      s4_b_q   <= 16'(s3_b_q) * 16'(s3_lvl_q) + rgbcf_pkg::ROUND_HALF;
    end
    if (en[4]) begin
      out_q.out_column <= s4_col_q;
      out_q.out_row    <= s4_row_q;
      out_q.red        <= rgbcf_pkg::div255(s4_r_q);
      out_q.green      <= rgbcf_pkg::div255(s4_g_q);
      out_q.blue       <= rgbcf_pkg::div255(s4_b_q);
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[rgbcf_pkg::NUM_STAGES-1];
  assign out_data_o  = out_q;

  // An empty output register never blocks the input side.
  a_no_stall_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> !in_stall_o
  ) else $error("input stalled while the output register is empty");

  // An accepted transaction always lands in the first stage.
  a_accept_fills_stage1: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && !in_stall_o) |=> valid_q[0]
  ) else $error("accepted transaction was not captured");

  // With blending off, the cross-fade weight captured is zero.
  a_blend_off_zero_amt: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (en[0] && !blend_en_q) |=> (s1_amt_q == 8'd0)
  ) else $error("cross-fade weight nonzero while blending is disabled");

  // Rows above the gradient start get full brightness.
  a_top_rows_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (en[0] && (in_data_i.row < rgbcf_pkg::GRAD_START_ROW))
    |=> (s1_grad_q == rgbcf_pkg::FULL_SCALE)
  ) else $error("gradient below full scale above the lower third");

endmodule
